FILE: hdl/vrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_pkg
// Widths, constants, sine table and helpers for the vertex rotate/project
// pipeline.
// ----------------------------------------------------------------------------
package vrp_pkg;

  localparam int VW  = 10;            // vertex coordinate
  localparam int SW  = 10;            // scale_size
  localparam int AW  = 6;             // angle index
  localparam int TW  = 13;            // shift
  localparam int MW  = VW + SW;       // scaled magnitude
  localparam int CW  = 20;            // signed coordinate in the datapath
  localparam int PW  = CW + 10;       // rotation product / sum
  localparam int DW  = 21;            // signed depth
  localparam int NW  = 28;            // numerator magnitude / quotient
  localparam int OW  = 24;            // screen coordinate
  localparam int ZW  = 15;            // reported depth
  localparam int RW  = 21;            // reciprocal width
  localparam int RS  = 26;            // reciprocal shift

  localparam int SCREEN_WIDTH_DEF  = 1024;
  localparam int SCREEN_HEIGHT_DEF = 768;

  // floor(n/50) == (n * RECIP50) >> RS for n < 2**MW
  localparam logic [RW-1:0] RECIP50 = 21'd1342178;
  localparam logic signed [9:0] PERSP      = 10'sd250;
  localparam logic signed [DW-1:0] DEPTH_BIAS = 21'sd200;
  localparam logic [AW-1:0] QUARTER_TURN = 6'd16;

  localparam logic [2:0] REG_ANGLE_X = 3'd0;
  localparam logic [2:0] REG_ANGLE_Y = 3'd1;
  localparam logic [2:0] REG_ANGLE_Z = 3'd2;
  localparam logic [2:0] REG_SCALE   = 3'd3;
  localparam logic [2:0] REG_SHIFT_X = 3'd4;
  localparam logic [2:0] REG_SHIFT_Y = 3'd5;
  localparam logic [2:0] REG_SHIFT_Z = 3'd6;

  localparam logic signed [8:0] SINE_ROM [64] = '{
    9'sd0, 9'sd12, 9'sd25, 9'sd37, 9'sd49, 9'sd60, 9'sd71, 9'sd81,
    9'sd90, 9'sd99, 9'sd107, 9'sd113, 9'sd118, 9'sd122, 9'sd125, 9'sd127,
    9'sd128, 9'sd127, 9'sd125, 9'sd122, 9'sd118, 9'sd113, 9'sd107, 9'sd99,
    9'sd90, 9'sd81, 9'sd71, 9'sd60, 9'sd49, 9'sd37, 9'sd25, 9'sd12,
    9'sd0, -9'sd12, -9'sd25, -9'sd37, -9'sd49, -9'sd60, -9'sd71, -9'sd81,
    -9'sd90, -9'sd99, -9'sd107, -9'sd113, -9'sd118, -9'sd122, -9'sd125, -9'sd127,
    -9'sd128, -9'sd127, -9'sd125, -9'sd122, -9'sd118, -9'sd113, -9'sd107, -9'sd99,
    -9'sd90, -9'sd81, -9'sd71, -9'sd60, -9'sd49, -9'sd37, -9'sd25, -9'sd12
  };

  typedef struct packed {
    logic [AW-1:0]        angle_x;
    logic [AW-1:0]        angle_y;
    logic [AW-1:0]        angle_z;
    logic [SW-1:0]        scale_size;
    logic signed [TW-1:0] shift_x;
    logic signed [TW-1:0] shift_y;
    logic signed [TW-1:0] shift_z;
  } cfg_t;

  // divide by 128, truncating toward zero
  function automatic logic signed [CW-1:0] div128(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = v[PW-1] ? v + PW'(127) : v;
    return CW'(t >>> 7);
  endfunction

endpackage

FILE: hdl/vertex_rotate_project_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_rotate_project_top
// Scale, rotate, translate and perspective-project one vertex per beat.
// ----------------------------------------------------------------------------
// Pipeline: transform, projection set-up, divider, output register.
// Throughput: one vertex per cycle while the output is accepted; the 28-stage divider is fully pipelined.
// Whole pipeline advances together; it holds while the output beat waits.
// Reset: synchronous, clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module vertex_rotate_project_top import vrp_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // vertex_x, vertex_y, vertex_z, pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,    // screen_x, screen_y, view_depth, pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam logic signed [NW:0] HALF_W = (NW+1)'(SCREEN_WIDTH / 2);
  localparam logic signed [NW:0] HALF_H = (NW+1)'(SCREEN_HEIGHT / 2);

  cfg_t cfg;
  logic en;

  logic                 t_valid;
  logic signed [CW-1:0] t_x, t_y;
  logic signed [DW-1:0] t_depth;

  logic signed [NW:0]   nx, ny;
  logic signed [DW-1:0] dfix;
  logic                 vld_p;
  logic [NW-1:0]        nmag_x, nmag_y;
  logic [DW-1:0]        dmag;
  logic                 neg_x, neg_y;
  logic [ZW-1:0]        zout_p;

  logic                 vld_dx, vld_dy;
  logic [NW-1:0]        q_x, q_y;
  logic [ZW:0]          sb_x;
  logic                 sb_y;
  logic signed [NW:0]   sq_x, sq_y;

  logic          ovalid;
  logic [OW-1:0] o_x, o_y;
  logic [ZW-1:0] o_z;

  assign cfg_ready = 1'b1;
  assign en        = !ovalid || m_tready;
  assign s_tready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{angle_x: '0, angle_y: '0, angle_z: '0, scale_size: SW'(50),
               shift_x: '0, shift_y: '0, shift_z: TW'(300)};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ANGLE_X: cfg.angle_x    <= cfg_data[AW-1:0];
        REG_ANGLE_Y: cfg.angle_y    <= cfg_data[AW-1:0];
        REG_ANGLE_Z: cfg.angle_z    <= cfg_data[AW-1:0];
        REG_SCALE:   cfg.scale_size <= cfg_data[SW-1:0];
        REG_SHIFT_X: cfg.shift_x    <= signed'(cfg_data);
        REG_SHIFT_Y: cfg.shift_y    <= signed'(cfg_data);
        REG_SHIFT_Z: cfg.shift_z    <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  vrp_transform u_transform (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .vx        (signed'(s_tdata[9:0])),
    .vy        (signed'(s_tdata[19:10])),
    .vz        (signed'(s_tdata[29:20])),
    .cfg       (cfg),
    .out_valid (t_valid),
    .ox        (t_x),
    .oy        (t_y),
    .odepth    (t_depth)
  );

  // projection set-up: coord*250, depth zero forced to one, magnitudes
  always_comb begin
    nx   = (NW+1)'(t_x) * (NW+1)'(PERSP);
    ny   = (NW+1)'(t_y) * (NW+1)'(PERSP);
    dfix = (t_depth == '0) ? DW'(1) : t_depth;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p <= 1'b0;
    end else if (en) begin
      vld_p <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nmag_x <= nx[NW] ? NW'(-nx) : NW'(nx);
      nmag_y <= ny[NW] ? NW'(-ny) : NW'(ny);
      dmag   <= dfix[DW-1] ? DW'(-dfix) : DW'(dfix);
      neg_x  <= nx[NW] ^ dfix[DW-1];
      neg_y  <= ny[NW] ^ dfix[DW-1];
      zout_p <= dfix[ZW-1:0];
    end
  end

  vrp_divider #(.SBW(ZW + 1)) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld_p),
    .num       (nmag_x),
    .den       (dmag),
    .sb_in     ({neg_x, zout_p}),
    .out_valid (vld_dx),
    .quo       (q_x),
    .sb_out    (sb_x)
  );

  vrp_divider #(.SBW(1)) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld_p),
    .num       (nmag_y),
    .den       (dmag),
    .sb_in     (neg_y),
    .out_valid (vld_dy),
    .quo       (q_y),
    .sb_out    (sb_y)
  );

  always_comb begin
    sq_x = sb_x[ZW] ? -signed'({1'b0, q_x}) : signed'({1'b0, q_x});
    sq_y = sb_y     ? -signed'({1'b0, q_y}) : signed'({1'b0, q_y});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (en) begin
      ovalid <= vld_dx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_x <= OW'(sq_x + HALF_W);
      o_y <= OW'(sq_y + HALF_H);
      o_z <= sb_x[ZW-1:0];
    end
  end

  assign m_tvalid = ovalid;
  assign m_tdata  = {1'b0, o_z, o_y, o_x};

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    vld_dx == vld_dy) else $error("divider lanes out of step");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    vld_p |-> dmag != '0) else $error("zero divisor entered divider");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid) else $error("output valid straight after reset");

endmodule

FILE: hdl/vrp_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_transform
// Scale, rotate about X, Y and Z, translate. Eight register stages.
// ----------------------------------------------------------------------------
module vrp_transform import vrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [VW-1:0] vx,
  input  logic signed [VW-1:0] vy,
  input  logic signed [VW-1:0] vz,
  input  cfg_t                 cfg,
  output logic                 out_valid,
  output logic signed [CW-1:0] ox,
  output logic signed [CW-1:0] oy,
  output logic signed [DW-1:0] odepth
);

  logic [7:0] vld;

  logic [VW-1:0] ax, ay, az;
  logic [MW-1:0] m1x, m1y, m1z;
  logic          n1x, n1y, n1z;
  logic [MW+RW-1:0] px, py, pz;
  logic [CW-1:0] qx, qy, qz;
  logic signed [CW-1:0] x2, y2, z2;
  logic signed [8:0] sxa, cxa, sya, cya, sza, cza;
  logic signed [PW-1:0] p3a, p3b, p3c, p3d;
  logic signed [CW-1:0] x3, x4, y4, z4;
  logic signed [PW-1:0] p5a, p5b, p5c, p5d;
  logic signed [CW-1:0] y5, x6, y6, z6;
  logic signed [PW-1:0] p7a, p7b, p7c, p7d;
  logic signed [CW-1:0] z7;

  always_comb begin
    ax = vx[VW-1] ? VW'(-vx) : VW'(vx);
    ay = vy[VW-1] ? VW'(-vy) : VW'(vy);
    az = vz[VW-1] ? VW'(-vz) : VW'(vz);
    px = (MW+RW)'(m1x) * (MW+RW)'(RECIP50);
    py = (MW+RW)'(m1y) * (MW+RW)'(RECIP50);
    pz = (MW+RW)'(m1z) * (MW+RW)'(RECIP50);
    qx = CW'(px[MW+RW-1:RS]);
    qy = CW'(py[MW+RW-1:RS]);
    qz = CW'(pz[MW+RW-1:RS]);
    sxa = SINE_ROM[cfg.angle_x];
    cxa = SINE_ROM[AW'(cfg.angle_x + QUARTER_TURN)];
    sya = SINE_ROM[cfg.angle_y];
    cya = SINE_ROM[AW'(cfg.angle_y + QUARTER_TURN)];
    sza = SINE_ROM[cfg.angle_z];
    cza = SINE_ROM[AW'(cfg.angle_z + QUARTER_TURN)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // scale magnitude
      m1x <= MW'(ax) * MW'(cfg.scale_size);
      m1y <= MW'(ay) * MW'(cfg.scale_size);
      m1z <= MW'(az) * MW'(cfg.scale_size);
      n1x <= vx[VW-1];
      n1y <= vy[VW-1];
      n1z <= vz[VW-1];
      // divide by fifty, restore sign
      x2 <= n1x ? -signed'(qx) : signed'(qx);
      y2 <= n1y ? -signed'(qy) : signed'(qy);
      z2 <= n1z ? -signed'(qz) : signed'(qz);
      // about X
      p3a <= PW'(y2) * PW'(cxa);
      p3b <= PW'(z2) * PW'(sxa);
      p3c <= PW'(y2) * PW'(sxa);
      p3d <= PW'(z2) * PW'(cxa);
      x3  <= x2;
      x4  <= x3;
      y4  <= div128(p3a - p3b);
      z4  <= div128(p3c + p3d);
      // about Y
      p5a <= PW'(x4) * PW'(cya);
      p5b <= PW'(z4) * PW'(sya);
      p5c <= PW'(z4) * PW'(cya);
      p5d <= PW'(x4) * PW'(sya);
      y5  <= y4;
      x6  <= div128(p5a + p5b);
      z6  <= div128(p5c - p5d);
      y6  <= y5;
      // about Z
      p7a <= PW'(x6) * PW'(cza);
      p7b <= PW'(y6) * PW'(sza);
      p7c <= PW'(x6) * PW'(sza);
      p7d <= PW'(y6) * PW'(cza);
      z7  <= z6;
      // translate, depth
      ox     <= div128(p7a - p7b) + CW'(cfg.shift_x);
      oy     <= div128(p7c + p7d) + CW'(cfg.shift_y);
      odepth <= DW'(z7) + DW'(cfg.shift_z) + DEPTH_BIAS;
    end
  end

  assign out_valid = vld[7];

endmodule

FILE: hdl/vrp_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_divider
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module vrp_divider import vrp_pkg::*; #(
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [NW-1:0]  num,
  input  logic [DW-1:0]  den,
  input  logic [SBW-1:0] sb_in,
  output logic           out_valid,
  output logic [NW-1:0]  quo,
  output logic [SBW-1:0] sb_out
);

  logic [NW-1:0]  w  [NW];
  logic [DW-1:0]  r  [NW];
  logic [DW-1:0]  d  [NW];
  logic [SBW-1:0] sb [NW];
  logic [NW-1:0]  v;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [NW-1:0]  w_src;
    logic [DW-1:0]  r_src;
    logic [DW-1:0]  d_src;
    logic [SBW-1:0] sb_src;
    logic           v_src;
    logic [DW:0]    t;
    logic           ge;

    if (i == 0) begin : g_first
      assign w_src  = num;
      assign r_src  = '0;
      assign d_src  = den;
      assign sb_src = sb_in;
      assign v_src  = in_valid;
    end else begin : g_next
      assign w_src  = w[i-1];
      assign r_src  = r[i-1];
      assign d_src  = d[i-1];
      assign sb_src = sb[i-1];
      assign v_src  = v[i-1];
    end

    assign t  = {r_src, w_src[NW-1]};
    assign ge = t >= {1'b0, d_src};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r[i]  <= ge ? DW'(t - {1'b0, d_src}) : t[DW-1:0];
        w[i]  <= {w_src[NW-2:0], ge};
        d[i]  <= d_src;
        sb[i] <= sb_src;
      end
    end
  end

  assign out_valid = v[NW-1];
  assign quo       = w[NW-1];
  assign sb_out    = sb[NW-1];

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for vertex_rotate_project_top: drives vertex beats and
// register writes, predicts the projected point and depth for each vertex
// and compares every output beat in order, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import vrp_pkg::*;

  localparam int LIMIT = 400000;
  localparam int PIPE_DRAIN = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  // packed from the top bit down: depth, screen_y, screen_x
  typedef struct packed {
    logic [14:0] depth;
    logic [23:0] sy;
    logic [23:0] sx;
  } point_t;

  point_t      point_q[$];
  int          errors = 0;
  int          cycles = 0;
  bit          rx_enable = 1'b0;

  // predictor copy of the registers
  int          ang_x, ang_y, ang_z, size;
  longint      off_x, off_y, off_z;

  vertex_rotate_project_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t timeout", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint sine_of(int a);
    return longint'(SINE_ROM[a & 63]);
  endfunction

  function automatic point_t project(logic [9:0] vx, logic [9:0] vy, logic [9:0] vz);
    longint x, y, z, t1, t2, d, sx, cx, sy, cy, sn, cn;
    point_t p;
    x = longint'($signed(vx)) * size / 50;
    y = longint'($signed(vy)) * size / 50;
    z = longint'($signed(vz)) * size / 50;
    sx = sine_of(ang_x); cx = sine_of(ang_x + 16);
    sy = sine_of(ang_y); cy = sine_of(ang_y + 16);
    sn = sine_of(ang_z); cn = sine_of(ang_z + 16);
    t1 = (y * cx - z * sx) / 128; t2 = (y * sx + z * cx) / 128; y = t1; z = t2;
    t1 = (x * cy + z * sy) / 128; t2 = (z * cy - x * sy) / 128; x = t1; z = t2;
    t1 = (x * cn - y * sn) / 128; t2 = (x * sn + y * cn) / 128; x = t1; y = t2;
    x += off_x; y += off_y; z += off_z;
    d = 200 + z;
    if (d == 0) d = 1;
    p.sx = 24'(x * 250 / d + 512);
    p.sy = 24'(y * 250 / d + 384);
    p.depth = 15'(d);
    return p;
  endfunction

  // output side: random stall, check each beat against oldest prediction
  initial begin
    int     w;
    point_t got, want;
    forever begin
      @(negedge clk);
      if (!rx_enable) begin
        m_tready <= 1'b0;
      end else begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 4) == 0) w = 0;
        if (w > 0) begin
          m_tready <= 1'b0;
          repeat (w) @(negedge clk);
        end
        m_tready <= 1'b1;
        do @(posedge clk); while (!m_tvalid);
        got = m_tdata[62:0];
        if (point_q.size() == 0) begin
          $display("%0t unexpected beat %h", $time, got);
          errors++;
        end else begin
          want = point_q.pop_front();
          if (got.sx !== want.sx)
            $display("%0t screen_x exp %h got %h", $time, want.sx, got.sx);
          if (got.sy !== want.sy)
            $display("%0t screen_y exp %h got %h", $time, want.sy, got.sy);
          if (got.depth !== want.depth)
            $display("%0t view_depth exp %h got %h", $time, want.depth, got.depth);
          if (got !== want) errors++;
        end
      end
    end
  end

  // leaves tvalid high after the beat so that beats can follow back to back
  task automatic send_vertex(logic [9:0] vx, logic [9:0] vy, logic [9:0] vz,
                             bit no_gap = 0);
    int w;
    w = no_gap ? 0 : $urandom_range(0, 13);
    if (!no_gap && $urandom_range(0, 3) == 0) w = 0;
    if (w > 0) begin
      s_tvalid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    s_tdata <= {2'b0, vz, vy, vx};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    point_q.push_back(project(vx, vy, vz));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (point_q.size() != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [12:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ANGLE_X: ang_x = val[5:0];
      REG_ANGLE_Y: ang_y = val[5:0];
      REG_ANGLE_Z: ang_z = val[5:0];
      REG_SCALE:   size  = val[9:0];
      REG_SHIFT_X: off_x = longint'($signed(val));
      REG_SHIFT_Y: off_y = longint'($signed(val));
      REG_SHIFT_Z: off_z = longint'($signed(val));
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_all(int ax, int ay, int az, int sz, int tx, int ty, int tz);
    write_reg(REG_ANGLE_X, 13'(ax));
    write_reg(REG_ANGLE_Y, 13'(ay));
    write_reg(REG_ANGLE_Z, 13'(az));
    write_reg(REG_SCALE, 13'(sz));
    write_reg(REG_SHIFT_X, 13'(tx));
    write_reg(REG_SHIFT_Y, 13'(ty));
    write_reg(REG_SHIFT_Z, 13'(tz));
  endtask

  task automatic send_random(int n);
    repeat (n)
      send_vertex(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                  10'($urandom_range(0, 1023)));
  endtask

  task automatic test_reset_defaults();
    send_vertex(10'sd0, 10'sd0, 10'sd0);
    send_vertex(10'sd511, 10'sd511, 10'sd511);
    send_vertex(-10'sd512, -10'sd512, -10'sd512);
    send_vertex(10'sd511, -10'sd512, 10'sd0);
    send_vertex(10'h155, 10'h2aa, 10'h3ff);
    wait_idle();
  endtask

  task automatic test_extremes();
    set_all(63, 63, 63, 512, 4095, 4095, 4095);
    send_vertex(10'sd511, 10'sd511, 10'sd511);
    send_vertex(-10'sd512, -10'sd512, -10'sd512);
    wait_idle();
    set_all(0, 0, 0, 0, -4096, -4096, -4096);
    send_vertex(10'sd511, -10'sd512, 10'sd1);
    wait_idle();
    // scale above the nominal range
    set_all(16, 32, 48, 1023, 0, 0, 300);
    send_vertex(10'sd511, 10'sd511, 10'sd511);
    send_vertex(-10'sd512, 10'sd100, -10'sd7);
    wait_idle();
  endtask

  task automatic test_zero_depth();
    // z = 0 after transform, shift_z = -200 gives depth 0 -> 1
    set_all(0, 0, 0, 50, 3, -5, -200);
    send_vertex(10'sd7, 10'sd9, 10'sd0);
    send_vertex(-10'sd512, 10'sd511, 10'sd0);
    wait_idle();
    write_reg(REG_SHIFT_Z, -13'sd199);
    send_vertex(10'sd1, 10'sd1, -10'sd1);
    wait_idle();
  endtask

  task automatic test_bad_index();
    write_reg(3'd7, 13'h1fff);
    send_vertex(10'sd100, -10'sd50, 10'sd25);
    wait_idle();
  endtask

  task automatic test_random_settings();
    repeat (8) begin
      set_all($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
              $urandom_range(0, 512), $urandom_range(0, 8191) - 4096,
              $urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096);
      send_random(45);
      wait_idle();
    end
  endtask

  task automatic test_back_to_back();
    set_all(5, 21, 40, 77, -300, 250, 600);
    repeat (40) send_vertex(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                            10'($urandom_range(0, 1023)), 1);
    send_random(30);
    // hold off until the pipeline has emptied, then resume
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (point_q.size() != 0) @(negedge clk);
    send_random(20);
    wait_idle();
  endtask

  initial begin
    ang_x = 0; ang_y = 0; ang_z = 0; size = 50;
    off_x = 0; off_y = 0; off_z = 300;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    rx_enable = 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_extremes();
    test_zero_depth();
    test_bad_index();
    test_random_settings();
    test_back_to_back();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
